// ===== rtl/core/ast_pkg.sv =====
// Shared constants, codes and helpers of the assembly source tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ast_pkg;

    // Default sizes
    localparam int DEF_OFFSET_BITS    = 32;
    localparam int DEF_LENGTH_BITS    = 16;
    localparam int DEF_LINE_BITS      = 24;
    localparam int DEF_NUM_SCAN_CHARS = 63;

    localparam int KIND_BITS = 5;
    localparam int COL_BITS  = 16;
    localparam int VAL_BITS  = 64;

    // Pending token modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_CR      = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_LT      = 4'd3;
    localparam logic [3:0] M_GT      = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_NUMBER  = 4'd6;
    localparam logic [3:0] M_IDENT   = 4'd7;

    // Token kinds
    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_NEWLINE = 5'd1;
    localparam logic [4:0] K_COMMENT = 5'd2;
    localparam logic [4:0] K_STAR    = 5'd3;
    localparam logic [4:0] K_SINGLE0 = 5'd4;
    localparam logic [4:0] K_LSHIFT  = 5'd18;
    localparam logic [4:0] K_RSHIFT  = 5'd19;
    localparam logic [4:0] K_ERROR   = 5'd20;
    localparam logic [4:0] K_STRING  = 5'd21;
    localparam logic [4:0] K_NUMBER  = 5'd22;
    localparam logic [4:0] K_IDENT   = 5'd23;

    // Radix select
    localparam logic [1:0] R_DEC = 2'd0;
    localparam logic [1:0] R_HEX = 2'd1;
    localparam logic [1:0] R_BIN = 2'd2;
    localparam logic [1:0] R_OCT = 2'd3;

    // Characters
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_AT     = 8'h40;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_LOW_X  = 8'h78;
    localparam logic [7:0] C_UP_X   = 8'h58;

    // Kind of a single-character operator; K_END when c is none of them
    function automatic logic [4:0] f_single(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2E:   k = K_SINGLE0;           // .
            8'h3A:   k = K_SINGLE0 + 5'd1;    // :
            8'h2C:   k = K_SINGLE0 + 5'd2;    // ,
            8'h23:   k = K_SINGLE0 + 5'd3;    // #
            8'h28:   k = K_SINGLE0 + 5'd4;    // (
            8'h29:   k = K_SINGLE0 + 5'd5;    // )
            8'h2B:   k = K_SINGLE0 + 5'd6;    // +
            8'h2D:   k = K_SINGLE0 + 5'd7;    // -
            8'h2F:   k = K_SINGLE0 + 5'd8;    // /
            8'h26:   k = K_SINGLE0 + 5'd9;    // &
            8'h7C:   k = K_SINGLE0 + 5'd10;   // |
            8'h5E:   k = K_SINGLE0 + 5'd11;   // ^
            8'h7E:   k = K_SINGLE0 + 5'd12;   // ~
            8'h3D:   k = K_SINGLE0 + 5'd13;   // =
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Digit value, 63 for bytes that are no digit in any radix
    function automatic logic [5:0] f_digit(input logic [7:0] c);
        logic [5:0] d;
        if (f_is_digit(c)) begin
            d = 6'(c - 8'h30);
        end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
            d = 6'(c - 8'h57);
        end else if ((c >= 8'h41) && (c <= 8'h5A)) begin
            d = 6'(c - 8'h37);
        end else begin
            d = 6'd63;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ast_if.sv =====
// Handshake interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none
interface ast_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;
    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface ast_tok_if
    import ast_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int LINE_BITS   = DEF_LINE_BITS
);
    logic                       valid;
    logic                       ready;
    logic [KIND_BITS-1:0]       kind;
    logic [OFFSET_BITS-1:0]     start_offset;
    logic [LENGTH_BITS-1:0]     token_length;
    logic [LINE_BITS-1:0]       line_number;
    logic [COL_BITS-1:0]        column;
    logic signed [VAL_BITS-1:0] number_value;
    logic                       last_of_run;
    modport source (output valid, kind, start_offset, token_length, line_number, column,
                    number_value, last_of_run, input ready);
    modport sink   (input valid, kind, start_offset, token_length, line_number, column,
                    number_value, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ast_step.sv =====
// Lexer state and the combinational step that turns one byte into up to two tokens.
`timescale 1ns / 1ps
`default_nettype none
module ast_step
    import ast_pkg::*;
#(
    parameter int OFFSET_BITS    = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS    = DEF_LENGTH_BITS,
    parameter int LINE_BITS      = DEF_LINE_BITS,
    parameter int NUM_SCAN_CHARS = DEF_NUM_SCAN_CHARS,
    localparam int TW = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + COL_BITS
                        + VAL_BITS + 1
)(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_eot,
    output logic [1:0]         o_cnt,
    output logic [TW-1:0]      o_tok0,
    output logic [TW-1:0]      o_tok1
);

    localparam int SCW = $clog2(NUM_SCAN_CHARS + 1);
    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    // Token word: kind, start, length, line, column, value, last flag in bit 0
    function automatic logic [TW-1:0] f_tok(
        input logic [KIND_BITS-1:0]   k,
        input logic [OFFSET_BITS-1:0] s,
        input logic [LENGTH_BITS-1:0] l,
        input logic [LINE_BITS-1:0]   ln,
        input logic [COL_BITS-1:0]    cl,
        input logic [VAL_BITS-1:0]    v
    );
        return {k, s, l, ln, cl, v, 1'b0};
    endfunction

    // State
    logic [3:0]             r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [LENGTH_BITS-1:0] r_tlen, n_tlen;
    logic [LINE_BITS-1:0]   r_tline, n_tline;
    logic [COL_BITS-1:0]    r_tcol, n_tcol;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COL_BITS-1:0]    r_col, n_col;
    logic                   r_aft_nl, n_aft_nl;
    logic [1:0]             r_radix, n_radix;
    logic [VAL_BITS-1:0]    r_accum, n_accum;
    logic                   r_stop, n_stop;
    logic                   r_sat, n_sat;
    logic                   r_dq, n_dq;
    logic [SCW-1:0]         r_scan, n_scan;
    logic [1:0]             r_didx, n_didx;

    logic [TW-1:0]          toks [2];
    logic [1:0]             cnt;
    logic                   fresh;
    logic                   feed;
    logic                   skip;
    logic [4:0]             fl_kind;
    logic                   fl_ok;
    logic [4:0]             sk;
    logic [SCW-1:0]         idx;
    logic [5:0]             dig;
    logic [5:0]             rad;
    logic [VAL_BITS+3:0]    prod;
    logic                   is_x;

    always_comb begin
        n_mode = r_mode;  n_tstart = r_tstart; n_tlen = r_tlen; n_tline = r_tline;
        n_tcol = r_tcol;  n_off = r_off;       n_line = r_line; n_col = r_col;
        n_aft_nl = r_aft_nl; n_radix = r_radix; n_accum = r_accum; n_stop = r_stop;
        n_sat = r_sat;    n_dq = r_dq;         n_scan = r_scan; n_didx = r_didx;
        toks[0] = '0; toks[1] = '0;
        cnt = 2'd0; fresh = 1'b1; feed = 1'b0; skip = 1'b0;
        idx = '0; dig = '0; rad = '0; prod = '0;
        is_x = (i_ch == C_LOW_X) || (i_ch == C_UP_X);
        sk = f_single(i_ch);

        // What a flush of the pending token emits
        fl_ok = 1'b1;
        case (r_mode)
            M_CR:          fl_kind = K_NEWLINE;
            M_COMMENT:     fl_kind = K_COMMENT;
            M_LT, M_GT:    fl_kind = K_ERROR;
            M_STRING:      fl_kind = K_STRING;
            M_NUMBER:      fl_kind = K_NUMBER;
            M_IDENT:       fl_kind = K_IDENT;
            default: begin
                fl_kind = K_END;
                fl_ok = 1'b0;
            end
        endcase

        if (i_eot) begin
            // Flush, end token, back to reset state
            if (fl_ok) begin
                toks[0] = f_tok(fl_kind, r_tstart, r_tlen, r_tline, r_tcol,
                                (r_mode == M_NUMBER) ? r_accum : '0);
                cnt = 2'd1;
            end
            toks[cnt[0]] = f_tok(K_END, r_off, '0, r_line, r_col, '0);
            cnt = cnt + 2'd1;
            fresh = 1'b0;
            n_mode = M_IDLE; n_tstart = '0; n_tlen = '0; n_tline = LINE_BITS'(1);
            n_tcol = COL_BITS'(1); n_off = '0; n_line = LINE_BITS'(1);
            n_col = COL_BITS'(1); n_aft_nl = 1'b1; n_radix = R_DEC; n_accum = '0;
            n_stop = 1'b0; n_sat = 1'b0; n_dq = 1'b0; n_scan = '0; n_didx = '0;
        end else begin
            // Continue the pending token, or flush it
            case (r_mode)
                M_CR: begin
                    if (i_ch == C_LF) begin
                        toks[0] = f_tok(K_NEWLINE, r_tstart, LENGTH_BITS'(2), r_tline,
                                        r_tcol, '0);
                        cnt = 2'd1;
                        n_mode = M_IDLE;
                        n_off = r_off + OFFSET_BITS'(1);
                        fresh = 1'b0;
                    end
                end
                M_COMMENT: begin
                    if (i_ch != C_LF) fresh = 1'b0;
                end
                M_LT, M_GT: begin
                    if (i_ch == ((r_mode == M_LT) ? C_LT : C_GT)) begin
                        toks[0] = f_tok((r_mode == M_LT) ? K_LSHIFT : K_RSHIFT, r_tstart,
                                        LENGTH_BITS'(2), r_tline, r_tcol, '0);
                        cnt = 2'd1;
                        n_mode = M_IDLE;
                        n_off = r_off + OFFSET_BITS'(1);
                        n_col = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
                        fresh = 1'b0;
                    end
                end
                M_STRING: begin
                    if (i_ch == (r_dq ? C_DQUOTE : C_SQUOTE)) begin
                        toks[0] = f_tok(K_STRING, r_tstart, r_tlen, r_tline, r_tcol, '0);
                        cnt = 2'd1;
                        n_mode = M_IDLE;
                        n_off = r_off + OFFSET_BITS'(1);
                        n_col = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
                        fresh = 1'b0;
                    end else if (i_ch != C_LF) begin
                        fresh = 1'b0;
                    end
                end
                M_NUMBER, M_IDENT: begin
                    if (f_is_alpha(i_ch) || f_is_digit(i_ch) || i_ch == C_UNDER) begin
                        fresh = 1'b0;
                        feed = (r_mode == M_NUMBER);
                    end
                end
                default: ;
            endcase

            // Token grows by this byte
            if (!fresh && cnt == 2'd0) begin
                n_tlen = (r_tlen != '1) ? r_tlen + LENGTH_BITS'(1) : r_tlen;
                n_off  = r_off + OFFSET_BITS'(1);
                n_col  = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
            end

            // Byte opens a token
            if (fresh) begin
                if (fl_ok) begin
                    toks[0] = f_tok(fl_kind, r_tstart, r_tlen, r_tline, r_tcol,
                                    (r_mode == M_NUMBER) ? r_accum : '0);
                    cnt = 2'd1;
                end
                n_mode = M_IDLE; n_tstart = r_off; n_tlen = LENGTH_BITS'(1);
                n_tline = r_line; n_tcol = r_col;
                n_off = r_off + OFFSET_BITS'(1);
                n_col = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
                if (i_ch == C_LF || i_ch == C_CR) begin
                    if (i_ch == C_LF) begin
                        toks[cnt[0]] = f_tok(K_NEWLINE, r_off, LENGTH_BITS'(1), r_line,
                                             r_col, '0);
                        cnt = cnt + 2'd1;
                    end else begin
                        n_mode = M_CR;
                    end
                    n_line = (r_line != '1) ? r_line + LINE_BITS'(1) : r_line;
                    n_col = COL_BITS'(1);
                end else if (i_ch == C_SPACE || i_ch == C_TAB) begin
                    n_mode = M_IDLE;
                end else if (i_ch == C_SEMI || (i_ch == C_STAR && r_aft_nl)) begin
                    n_mode = M_COMMENT;
                end else if (i_ch == C_STAR || sk != K_END) begin
                    toks[cnt[0]] = f_tok((i_ch == C_STAR) ? K_STAR : sk, r_off,
                                         LENGTH_BITS'(1), r_line, r_col, '0);
                    cnt = cnt + 2'd1;
                end else if (i_ch == C_LT) begin
                    n_mode = M_LT;
                end else if (i_ch == C_GT) begin
                    n_mode = M_GT;
                end else if (i_ch == C_DQUOTE || i_ch == C_SQUOTE) begin
                    n_mode = M_STRING;
                    n_dq = (i_ch == C_DQUOTE);
                    n_tstart = r_off + OFFSET_BITS'(1);
                    n_tcol = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
                    n_tlen = '0;
                end else if (i_ch == C_DOLLAR || i_ch == C_PCT || i_ch == C_AT ||
                             f_is_digit(i_ch)) begin
                    n_mode = M_NUMBER; n_radix = R_DEC; n_accum = '0; n_stop = 1'b0;
                    n_sat = 1'b0; n_scan = '0; n_didx = '0;
                    feed = 1'b1;
                end else if (f_is_alpha(i_ch) || i_ch == C_UNDER) begin
                    n_mode = M_IDENT;
                end else begin
                    toks[cnt[0]] = f_tok(K_ERROR, r_off, LENGTH_BITS'(1), r_line, r_col,
                                         '0);
                    cnt = cnt + 2'd1;
                end
            end

            // Number digit accumulation, strtoull style
            if (feed && n_scan < SCW'(NUM_SCAN_CHARS)) begin
                idx = n_scan;
                n_scan = n_scan + SCW'(1);
                if (idx == '0) begin
                    n_didx = 2'd0;
                    skip = 1'b1;
                    if (i_ch == C_DOLLAR)    n_radix = R_HEX;
                    else if (i_ch == C_PCT)  n_radix = R_BIN;
                    else if (i_ch == C_AT)   n_radix = R_OCT;
                    else begin
                        n_radix = R_DEC;
                        skip = 1'b0;
                    end
                end else if (idx == SCW'(1) && n_radix == R_DEC && !n_stop &&
                             n_accum == '0 && is_x) begin
                    n_radix = R_HEX;
                    n_didx = 2'd0;
                    skip = 1'b1;
                end
                if (!skip && !n_stop) begin
                    if (n_radix == R_HEX && n_didx == 2'd1 && n_accum == '0 && is_x) begin
                        n_didx = 2'd2;
                    end else begin
                        dig = f_digit(i_ch);
                        case (n_radix)
                            R_HEX: begin
                                rad = 6'd16;
                                prod = {n_accum, 4'b0};
                            end
                            R_BIN: begin
                                rad = 6'd2;
                                prod = {3'b0, n_accum, 1'b0};
                            end
                            R_OCT: begin
                                rad = 6'd8;
                                prod = {1'b0, n_accum, 3'b0};
                            end
                            default: begin
                                rad = 6'd10;
                                prod = {1'b0, n_accum, 3'b0} + {3'b0, n_accum, 1'b0};
                            end
                        endcase
                        prod = prod + (VAL_BITS+4)'(dig);
                        if (dig >= rad) begin
                            n_stop = 1'b1;
                        end else begin
                            if (!n_sat) begin
                                if (prod[VAL_BITS+3:VAL_BITS] != 4'd0) begin
                                    n_sat = 1'b1;
                                    n_accum = '1;
                                end else begin
                                    n_accum = prod[VAL_BITS-1:0];
                                end
                            end
                            if (n_didx != 2'd3) n_didx = n_didx + 2'd1;
                        end
                    end
                end
            end

            n_aft_nl = (i_ch == C_LF) || (i_ch == C_CR);
        end

        // Mark the last token of this byte
        if (cnt != 2'd0) toks[cnt[0] ^ 1'b1][0] = 1'b1;
    end

    assign o_cnt  = i_valid ? cnt : 2'd0;
    assign o_tok0 = toks[0];
    assign o_tok1 = toks[1];

    // State update on each registered byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_tstart <= '0; r_tlen <= '0; r_tline <= LINE_BITS'(1);
            r_tcol <= COL_BITS'(1); r_off <= '0; r_line <= LINE_BITS'(1);
            r_col <= COL_BITS'(1); r_aft_nl <= 1'b1; r_radix <= R_DEC; r_accum <= '0;
            r_stop <= 1'b0; r_sat <= 1'b0; r_dq <= 1'b0; r_scan <= '0; r_didx <= '0;
        end else if (i_valid) begin
            r_mode <= n_mode; r_tstart <= n_tstart; r_tlen <= n_tlen; r_tline <= n_tline;
            r_tcol <= n_tcol; r_off <= n_off; r_line <= n_line; r_col <= n_col;
            r_aft_nl <= n_aft_nl; r_radix <= n_radix; r_accum <= n_accum;
            r_stop <= n_stop; r_sat <= n_sat; r_dq <= n_dq; r_scan <= n_scan;
            r_didx <= n_didx;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/assembly_source_tokenizer_top.sv =====
// Top level of the assembly source tokenizer: input register, lexer step, token queue.
//
// Usage:
//   i_in carries one source word per handshake: a byte in ch, or end_of_text = 1
//   to close the text. o_tok carries one token word per handshake: kind,
//   start offset, length, line, column, number value and last_of_run, which
//   marks the last token that one input word produced (zero, one or two).
//   A token caused by an accepted word passes the input register and is then
//   written to the token queue, from which it is offered. Throughput: one input
//   word per cycle while the token side keeps up; the lexer step runs once per
//   cycle between the input register and an eight-entry token queue, so a word
//   that yields two tokens is offered as two token words.
//   i_in.ready is high while the queued tokens plus two for a word still in the
//   input register number at most four; when the receiver stalls, tokens wait
//   in the queue and input stalls once that count passes four.
//   Reset (synchronous, active low) empties the queue and returns the lexer to
//   the start of a text: offset 0, line 1, column 1. After an end word the
//   lexer is at the start of a new text again.
`timescale 1ns / 1ps
`default_nettype none
module assembly_source_tokenizer_top
    import ast_pkg::*;
#(
    parameter int OFFSET_BITS    = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS    = DEF_LENGTH_BITS,
    parameter int LINE_BITS      = DEF_LINE_BITS,
    parameter int NUM_SCAN_CHARS = DEF_NUM_SCAN_CHARS
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ast_in_if.sink    i_in,
    ast_tok_if.source o_tok
);

    localparam int TW    = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS + COL_BITS
                           + VAL_BITS + 1;
    localparam int DEPTH = 8;
    localparam int AW    = $clog2(DEPTH);

    // Input register
    logic       r_v;
    logic [7:0] r_ch;
    logic       r_eot;
    logic       in_acc;

    // Token queue
    logic [TW-1:0] r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [1:0]    push;
    logic          pop;
    logic [TW-1:0] tok0, tok1, head;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_cnt + (r_v ? (AW+1)'(2) : (AW+1)'(0))) <= (AW+1)'(DEPTH - 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch  <= i_in.ch;
            r_eot <= i_in.end_of_text;
        end
    end

    ast_step #(
        .OFFSET_BITS    (OFFSET_BITS),
        .LENGTH_BITS    (LENGTH_BITS),
        .LINE_BITS      (LINE_BITS),
        .NUM_SCAN_CHARS (NUM_SCAN_CHARS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .i_ch    (r_ch),
        .i_eot   (r_eot),
        .o_cnt   (push),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    // Queue write, one or two words per cycle
    always_ff @(posedge i_clk) begin
        if (push != 2'd0) r_q[r_wp] <= tok0;
        if (push == 2'd2) r_q[r_wp + AW'(1)] <= tok1;
    end

    assign pop = o_tok.valid && o_tok.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(push);
            r_rp  <= r_rp + AW'(pop);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // Head of queue drives the token port
    assign head               = r_q[r_rp];
    assign o_tok.valid        = (r_cnt != '0);
    assign {o_tok.kind, o_tok.start_offset, o_tok.token_length, o_tok.line_number,
            o_tok.column, o_tok.number_value, o_tok.last_of_run} = head;

endmodule
`default_nettype wire
